FILE: rtl/rmq_pkg.sv
// ----------------------------------------------------------------------------
// rmq_pkg
// Shared constants, codes and types of the range-minimum engine.
// ----------------------------------------------------------------------------
package rmq_pkg;

    localparam int DEPTH      = 1024;
    localparam int BLOCK_SIZE = 32;
    localparam int NUM_BLOCKS = (DEPTH + BLOCK_SIZE - 1) / BLOCK_SIZE;

    localparam int DATA_W = 32;
    localparam int IDX_W  = $clog2(DEPTH);
    localparam int CNT_W  = IDX_W + 1;
    localparam int OFF_W  = $clog2(BLOCK_SIZE);
    localparam int BLK_W  = IDX_W - OFF_W;
    localparam int OP_W   = 2;
    localparam int STAT_W = 2;

    localparam logic signed [DATA_W-1:0] MOST_POS = {1'b0, {(DATA_W-1){1'b1}}};

    typedef enum logic [OP_W-1:0] {
        OP_APPEND = 2'd0,
        OP_QUERY  = 2'd1,
        OP_CLEAR  = 2'd2
    } t_op;

    typedef enum logic [STAT_W-1:0] {
        ST_OK    = 2'd0,
        ST_RANGE = 2'd1,
        ST_FULL  = 2'd2
    } t_status;

    // sequencer to compare unit
    typedef struct packed {
        logic init;
        logic fold_elem;
        logic fold_blk;
    } t_min_ctrl;

endpackage

FILE: rtl/rmq_in_if.sv
// ----------------------------------------------------------------------------
// rmq_in_if
// Request channel: op code, element value and query range.
// ----------------------------------------------------------------------------
interface rmq_in_if
    import rmq_pkg::*;
();
    logic                     valid;
    logic                     ready;
    logic [OP_W-1:0]          op;
    logic signed [DATA_W-1:0] value;
    logic [IDX_W-1:0]         left;
    logic [IDX_W-1:0]         right;

    modport source (output valid, output op, output value, output left, output right,
                    input ready);
    modport sink   (input valid, input op, input value, input left, input right,
                    output ready);
endinterface

FILE: rtl/rmq_out_if.sv
// ----------------------------------------------------------------------------
// rmq_out_if
// Result channel: range minimum and status.
// ----------------------------------------------------------------------------
interface rmq_out_if
    import rmq_pkg::*;
();
    logic                     valid;
    logic                     ready;
    logic signed [DATA_W-1:0] min_value;
    logic [STAT_W-1:0]        status;

    modport source (output valid, output min_value, output status, input ready);
    modport sink   (input valid, input min_value, input status, output ready);
endinterface

FILE: rtl/rmq_ram.sv
// ----------------------------------------------------------------------------
// rmq_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module rmq_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 1024
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;
endmodule

FILE: rtl/rmq_min_unit.sv
// ----------------------------------------------------------------------------
// rmq_min_unit
// Shared signed compare unit folding element or block minimum reads into
// the running query minimum.
// ----------------------------------------------------------------------------
module rmq_min_unit
    import rmq_pkg::*;
(
    input  logic                     i_clk,
    input  t_min_ctrl                i_ctrl,
    input  logic signed [DATA_W-1:0] i_elem,
    input  logic signed [DATA_W-1:0] i_blk,
    output logic signed [DATA_W-1:0] o_acc
);
    logic signed [DATA_W-1:0] r_acc;
    logic signed [DATA_W-1:0] n_acc;
    logic signed [DATA_W-1:0] w_sel;

    assign w_sel = i_ctrl.fold_elem ? i_elem : i_blk;

    always_comb begin
        n_acc = r_acc;
        if (i_ctrl.init) begin
            n_acc = MOST_POS;
        end else if ((i_ctrl.fold_elem || i_ctrl.fold_blk) && (w_sel < r_acc)) begin
            n_acc = w_sel;
        end
    end

    always_ff @(posedge i_clk) begin
        r_acc <= n_acc;
    end

    assign o_acc = r_acc;
endmodule

FILE: rtl/rmq_seq.sv
// ----------------------------------------------------------------------------
// rmq_seq
// Query sequencer: range and full checks, scan address generation over the left edge
// block, whole block minima and right edge block, and the result register.
// ----------------------------------------------------------------------------
module rmq_seq
    import rmq_pkg::*;
(
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_in_valid,
    input  logic [OP_W-1:0]          i_op,
    input  logic [IDX_W-1:0]         i_left,
    input  logic [IDX_W-1:0]         i_right,
    input  logic [CNT_W-1:0]         i_count,
    output logic                     o_in_ready,
    output logic [IDX_W-1:0]         o_elem_raddr,
    output logic [BLK_W-1:0]         o_blk_raddr,
    output t_min_ctrl                o_ctrl,
    input  logic signed [DATA_W-1:0] i_acc,
    output logic                     o_out_valid,
    input  logic                     i_out_ready,
    output logic signed [DATA_W-1:0] o_min_value,
    output logic [STAT_W-1:0]        o_status
);
    typedef enum logic [2:0] {
        S_IDLE,
        S_SCAN_L,
        S_SCAN_B,
        S_SCAN_R,
        S_DRAIN,
        S_DONE
    } t_state;

    t_state                   r_state,      n_state;
    logic [IDX_W-1:0]         r_addr,       n_addr;
    logic [BLK_W-1:0]         r_blk,        n_blk;
    logic [BLK_W-1:0]         r_lb,         n_lb;
    logic [BLK_W-1:0]         r_rb,         n_rb;
    logic [IDX_W-1:0]         r_right,      n_right;
    logic                     r_fold_elem,  n_fold_elem;
    logic                     r_fold_blk,   n_fold_blk;
    t_status                  r_status,     n_status;
    logic                     r_out_valid,  n_out_valid;
    logic signed [DATA_W-1:0] r_min_value,  n_min_value;
    t_status                  r_out_status, n_out_status;

    logic             w_init;
    logic [IDX_W-1:0] w_l_end;
    logic [IDX_W-1:0] w_r_start;

    // left scan stops at the block end, or at right when both share a block
    assign w_l_end   = (r_lb == r_rb) ? r_right : {r_lb, {OFF_W{1'b1}}};
    assign w_r_start = {r_rb, {OFF_W{1'b0}}};

    always_comb begin
        n_state      = r_state;
        n_addr       = r_addr;
        n_blk        = r_blk;
        n_lb         = r_lb;
        n_rb         = r_rb;
        n_right      = r_right;
        n_fold_elem  = 1'b0;
        n_fold_blk   = 1'b0;
        n_status     = r_status;
        n_out_valid  = r_out_valid;
        n_min_value  = r_min_value;
        n_out_status = r_out_status;
        w_init       = 1'b0;

        if (r_out_valid && i_out_ready) begin
            n_out_valid = 1'b0;
        end

        case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    case (i_op)
                        OP_APPEND: begin
                            if (i_count >= CNT_W'(DEPTH)) begin
                                n_status = ST_FULL;
                                n_state  = S_DONE;
                            end
                        end
                        OP_QUERY: begin
                            if ((i_left > i_right) || ({1'b0, i_right} >= i_count)) begin
                                n_status = ST_RANGE;
                                n_state  = S_DONE;
                            end else begin
                                w_init   = 1'b1;
                                n_addr   = i_left;
                                n_lb     = i_left[IDX_W-1:OFF_W];
                                n_rb     = i_right[IDX_W-1:OFF_W];
                                n_right  = i_right;
                                n_status = ST_OK;
                                n_state  = S_SCAN_L;
                            end
                        end
                        default: ;
                    endcase
                end
            end
            S_SCAN_L: begin
                n_fold_elem = 1'b1;
                if (r_addr == w_l_end) begin
                    if (r_lb == r_rb) begin
                        n_state = S_DRAIN;
                    end else if (BLK_W'(r_rb - r_lb) != BLK_W'(1)) begin
                        n_blk   = BLK_W'(r_lb + 1'b1);
                        n_state = S_SCAN_B;
                    end else begin
                        n_addr  = w_r_start;
                        n_state = S_SCAN_R;
                    end
                end else begin
                    n_addr = IDX_W'(r_addr + 1'b1);
                end
            end
            S_SCAN_B: begin
                n_fold_blk = 1'b1;
                if (r_blk == BLK_W'(r_rb - 1'b1)) begin
                    n_addr  = w_r_start;
                    n_state = S_SCAN_R;
                end else begin
                    n_blk = BLK_W'(r_blk + 1'b1);
                end
            end
            S_SCAN_R: begin
                n_fold_elem = 1'b1;
                if (r_addr == r_right) begin
                    n_state = S_DRAIN;
                end else begin
                    n_addr = IDX_W'(r_addr + 1'b1);
                end
            end
            S_DRAIN: begin
                // last read folds in at the end of this cycle
                n_state = S_DONE;
            end
            S_DONE: begin
                if (!r_out_valid || i_out_ready) begin
                    n_out_valid  = 1'b1;
                    n_min_value  = (r_status == ST_OK) ? i_acc : '0;
                    n_out_status = r_status;
                    n_state      = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_fold_elem <= 1'b0;
            r_fold_blk  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_fold_elem <= n_fold_elem;
            r_fold_blk  <= n_fold_blk;
            r_out_valid <= n_out_valid;
        end
        r_addr       <= n_addr;
        r_blk        <= n_blk;
        r_lb         <= n_lb;
        r_rb         <= n_rb;
        r_right      <= n_right;
        r_status     <= n_status;
        r_min_value  <= n_min_value;
        r_out_status <= n_out_status;
    end

    assign o_in_ready     = (r_state == S_IDLE);
    assign o_elem_raddr   = r_addr;
    assign o_blk_raddr    = r_blk;
    assign o_ctrl.init      = w_init;
    assign o_ctrl.fold_elem = r_fold_elem;
    assign o_ctrl.fold_blk  = r_fold_blk;
    assign o_out_valid    = r_out_valid;
    assign o_min_value    = r_min_value;
    assign o_status       = r_out_status;
endmodule

FILE: rtl/range_minimum_query_sqrt_blocks.sv
// ----------------------------------------------------------------------------
// range_minimum_query_sqrt_blocks
// Range-minimum engine over a 1024-entry element store split into blocks of
// 32, with saved per-block minima.
//
//   channel  dir  handshake     payload
//   i_in     in   valid/ready   op, value, left, right
//   o_out    out  valid/ready   min_value, status
//
// append and clear are taken in idle; a query scans the left edge reads, the whole
// blocks between and the right edge reads, then drains and returns its result, with
// one compare per cycle through the shared min unit, each RAM with one read port.
// range errors and dropped appends go from idle straight to the result state.
// reset clears the element count and running block minimum; no clearing pass.
// a waiting result holds the sequencer before it returns to idle.
// ----------------------------------------------------------------------------
module range_minimum_query_sqrt_blocks
    import rmq_pkg::*;
(
    input  logic      i_clk,
    input  logic      i_rst_n,
    rmq_in_if.sink    i_in,
    rmq_out_if.source o_out
);
    logic [CNT_W-1:0]         r_count,   n_count;
    logic signed [DATA_W-1:0] r_run_min, n_run_min;

    logic                     w_accept;
    logic                     w_append;
    logic                     w_blk_last;
    logic signed [DATA_W-1:0] w_new_min;
    logic [IDX_W-1:0]         w_elem_raddr;
    logic [BLK_W-1:0]         w_blk_raddr;
    logic signed [DATA_W-1:0] w_elem_rdata;
    logic signed [DATA_W-1:0] w_blk_rdata;
    logic signed [DATA_W-1:0] w_acc;
    t_min_ctrl                w_ctrl;

    assign w_accept   = i_in.valid && i_in.ready;
    assign w_append   = w_accept && (i_in.op == OP_APPEND) && (r_count < CNT_W'(DEPTH));
    assign w_blk_last = (r_count[OFF_W-1:0] == {OFF_W{1'b1}});
    assign w_new_min  = (i_in.value < r_run_min) ? i_in.value : r_run_min;

    always_comb begin
        n_count   = r_count;
        n_run_min = r_run_min;
        if (w_accept && (i_in.op == OP_CLEAR)) begin
            n_count   = '0;
            n_run_min = MOST_POS;
        end else if (w_append) begin
            n_count   = CNT_W'(r_count + 1'b1);
            n_run_min = w_blk_last ? MOST_POS : w_new_min;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count   <= '0;
            r_run_min <= MOST_POS;
        end else begin
            r_count   <= n_count;
            r_run_min <= n_run_min;
        end
    end

    rmq_ram #(
        .WIDTH (DATA_W),
        .DEPTH (DEPTH)
    ) u_elem_ram (
        .i_clk   (i_clk),
        .i_we    (w_append),
        .i_waddr (r_count[IDX_W-1:0]),
        .i_wdata (i_in.value),
        .i_raddr (w_elem_raddr),
        .o_rdata (w_elem_rdata)
    );

    // block minimum saved as the block's last element goes in
    rmq_ram #(
        .WIDTH (DATA_W),
        .DEPTH (NUM_BLOCKS)
    ) u_blk_ram (
        .i_clk   (i_clk),
        .i_we    (w_append && w_blk_last),
        .i_waddr (r_count[IDX_W-1:OFF_W]),
        .i_wdata (w_new_min),
        .i_raddr (w_blk_raddr),
        .o_rdata (w_blk_rdata)
    );

    rmq_min_unit u_min_unit (
        .i_clk  (i_clk),
        .i_ctrl (w_ctrl),
        .i_elem (w_elem_rdata),
        .i_blk  (w_blk_rdata),
        .o_acc  (w_acc)
    );

    rmq_seq u_seq (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in_valid   (i_in.valid),
        .i_op         (i_in.op),
        .i_left       (i_in.left),
        .i_right      (i_in.right),
        .i_count      (r_count),
        .o_in_ready   (i_in.ready),
        .o_elem_raddr (w_elem_raddr),
        .o_blk_raddr  (w_blk_raddr),
        .o_ctrl       (w_ctrl),
        .i_acc        (w_acc),
        .o_out_valid  (o_out.valid),
        .i_out_ready  (o_out.ready),
        .o_min_value  (o_out.min_value),
        .o_status     (o_out.status)
    );

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CNT_W'(DEPTH))
        else $error("element count beyond store depth");

    a_append_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_append |=> (r_count == CNT_W'($past(r_count) + 1'b1)))
        else $error("append did not advance element count");

    a_fold_excl: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(w_ctrl.fold_elem && w_ctrl.fold_blk))
        else $error("element and block fold in the same cycle");

    a_no_write_in_scan: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_ctrl.fold_elem || w_ctrl.fold_blk) |-> !w_append)
        else $error("store written during a query scan");

    a_err_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out.valid && (o_out.status != ST_OK)) |-> (o_out.min_value == '0))
        else $error("error result carries a nonzero minimum");
endmodule
